@@ hw/rtl/dopc_pkg.sv @@
// shared types and constants for the digital output pulse controller
`timescale 1ns / 1ps

package dopc_pkg;

  // command codes carried in the op field
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_RESET  = 3'd2,
    OP_TOGGLE = 3'd3,
    OP_PULSE  = 3'd4,
    OP_DUTY   = 3'd5
  } dopc_op_e;

  // configuration register indexes
  localparam logic [1:0] CfgPwmMode    = 2'd0;
  localparam logic [1:0] CfgIsRelay    = 2'd1;
  localparam logic [1:0] CfgFullScale  = 2'd2;
  localparam logic [1:0] CfgRelayHold  = 2'd3;

  localparam logic [15:0] FullScaleRst = 16'd1000;
  localparam logic [15:0] RelayHoldRst = 16'd100;

  // duty arithmetic: 100 percent in hundredths
  localparam logic [13:0] DutyFull = 14'd10000;
  // floor(p / 10000) = floor((p >> 4) / 625), the latter by reciprocal
  // ceil(2^36 / 625), exact for p below 2^30
  localparam int unsigned DivShift = 36;
  localparam logic [26:0] DivRecip = 27'd109951163;

  localparam int unsigned InWidth  = 64;
  localparam int unsigned OutWidth = 72;

  // command fields that travel down the pipe beside the duty scaler
  typedef struct packed {
    dopc_op_e    op;
    logic [7:0]  pulse_count;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } dopc_cmd_t;

endpackage

@@ hw/rtl/dopc_duty_scale.sv @@
// two-stage duty to compare-value scaler: multiply, then divide by 10000
`timescale 1ns / 1ps

module dopc_duty_scale (
  input  logic        clk_i,
  input  logic        prod_en_i,
  input  logic        quot_en_i,
  input  logic [15:0] duty_i,
  input  logic [15:0] full_scale_i,
  output logic [15:0] quot_o
);
  import dopc_pkg::*;

  logic [13:0] duty_clamped;
  logic [29:0] prod_d, prod_q;
  logic [52:0] recip_mul;
  logic [15:0] quot_q;

  // clamp to 100 percent, then scale by full scale
  assign duty_clamped = (duty_i > {2'b00, DutyFull}) ? DutyFull : duty_i[13:0];
  assign prod_d       = 30'(duty_clamped) * 30'(full_scale_i);

  // divide by 16 with a shift, by 625 with the reciprocal
  assign recip_mul = 53'(prod_q[29:4]) * 53'(DivRecip);

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q <= prod_d;
    end
    if (quot_en_i) begin
      quot_q <= recip_mul[DivShift+15:DivShift];
    end
  end

  assign quot_o = quot_q;

endmodule

@@ hw/rtl/digital_output_pulse_controller_core.sv @@
// top level of the digital output pulse controller
`timescale 1ns / 1ps
// throughput: one beat per cycle while the result stream is not stalled; the pipe is input
// register, duty product, duty quotient, then state update into the output register
// stages fill independently, so input is taken while a result waits
// reset: all channel state clears, registers return to plain output,
// non-relay, full scale 1000 and relay hold 100 ms

module digital_output_pulse_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // op[2:0], pulse_count[10:3], on_ms[26:11], off_ms[42:27],
  // duty_hundredths[58:43], zero fill [63:59]
  input  logic [dopc_pkg::InWidth-1:0]  s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // drive_on[0], drive_level[16:1], commanded_level[32:17], pulse_busy[33],
  // relay_cycle_count[65:34], accepted[66], zero fill [71:67]
  output logic [dopc_pkg::OutWidth-1:0] m_axis_tdata
);
  import dopc_pkg::*;

  // configuration registers
  logic        pwm_q, relay_q;
  logic [15:0] fs_q, rh_q;

  // pipe valids and enables
  logic      v1_q, v2_q, v3_q, ov_q;
  logic      en1, en2, en3, en_out, retire;
  dopc_cmd_t c1_q, c2_q, c3_q;
  logic [15:0] duty1_q;
  logic [15:0] quot;

  // channel state
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] drive_q, drive_d;
  logic [15:0] hold_q, hold_d;
  logic [8:0]  steps_q, steps_d;
  logic [15:0] on_q, on_d;
  logic [15:0] off_q, off_d;
  logic [31:0] cyc_q, cyc_d;
  logic        acc_d;

  logic [OutWidth-1:0] out_q, out_d;

  // a stage loads when it is empty or its beat moves on
  assign en_out = !ov_q || m_axis_tready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign retire = v3_q && en_out;

  assign s_axis_tready = en1;
  assign cfg_ready_o   = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q   <= 1'b0;
      relay_q <= 1'b0;
      fs_q    <= FullScaleRst;
      rh_q    <= RelayHoldRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPwmMode:   pwm_q   <= cfg_data_i[0];
        CfgIsRelay:   relay_q <= cfg_data_i[0];
        CfgFullScale: fs_q    <= cfg_data_i;
        CfgRelayHold: rh_q    <= cfg_data_i;
      endcase
    end
  end

  // pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= s_axis_tvalid;
      if (en2)    v2_q <= v1_q;
      if (en3)    v3_q <= v2_q;
      if (en_out) ov_q <= v3_q;
    end
  end

  // command payload beside the scaler
  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q.op          <= dopc_op_e'(s_axis_tdata[2:0]);
      c1_q.pulse_count <= s_axis_tdata[10:3];
      c1_q.on_ms       <= s_axis_tdata[26:11];
      c1_q.off_ms      <= s_axis_tdata[42:27];
      duty1_q          <= s_axis_tdata[58:43];
    end
    if (en2) c2_q <= c1_q;
    if (en3) c3_q <= c2_q;
  end

  dopc_duty_scale u_duty_scale (
    .clk_i        (clk_i),
    .prod_en_i    (en2),
    .quot_en_i    (en3),
    .duty_i       (duty1_q),
    .full_scale_i (fs_q),
    .quot_o       (quot)
  );

  // state update for the beat leaving the last stage
  always_comb begin
    cmd_d   = cmd_q;
    drive_d = drive_q;
    hold_d  = hold_q;
    steps_d = steps_q;
    on_d    = on_q;
    off_d   = off_q;
    cyc_d   = cyc_q;
    acc_d   = 1'b1;
    case (c3_q.op)
      OP_TICK: begin
        if (hold_q != 16'd0) begin
          // hold pending: only count it down
          hold_d = hold_q - 16'd1;
        end else if (steps_q != 9'd0) begin
          // pulse train step: toggle the drive, load the next phase
          if (relay_q && drive_q == 16'd0) cyc_d = cyc_q + 32'd1;
          if (drive_q != 16'd0)  drive_d = 16'd0;
          else if (pwm_q)        drive_d = fs_q;
          else                   drive_d = 16'd1;
          hold_d  = steps_q[0] ? off_q : on_q;
          steps_d = steps_q - 9'd1;
        end else if (pwm_q) begin
          if (drive_q != cmd_q) begin
            drive_d = cmd_q;
            if (relay_q) hold_d = rh_q;
          end
        end else if ((cmd_q != 16'd0) != (drive_q != 16'd0)) begin
          // plain output follows the command by nonzero-ness
          drive_d = {15'd0, cmd_q != 16'd0};
          cmd_d   = {15'd0, cmd_q != 16'd0};
          if (relay_q && cmd_q != 16'd0) cyc_d = cyc_q + 32'd1;
          if (relay_q) hold_d = rh_q;
        end
      end
      OP_SET: begin
        cmd_d = pwm_q ? fs_q : 16'd1;
      end
      OP_RESET: begin
        cmd_d = 16'd0;
        if (!pwm_q && relay_q && cmd_q != 16'd0) hold_d = rh_q;
      end
      OP_TOGGLE: begin
        if (cmd_q != 16'd0) cmd_d = 16'd0;
        else                cmd_d = pwm_q ? fs_q : 16'd1;
      end
      OP_PULSE: begin
        if (relay_q && (c3_q.on_ms < rh_q || c3_q.off_ms < rh_q)) begin
          acc_d = 1'b0;
        end else begin
          steps_d = {c3_q.pulse_count, 1'b0};
          on_d    = c3_q.on_ms;
          off_d   = c3_q.off_ms;
        end
      end
      OP_DUTY: begin
        if (!pwm_q) acc_d = 1'b0;
        else        cmd_d = quot;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  always_comb begin
    out_d        = '0;
    out_d[0]     = drive_d != 16'd0;
    out_d[16:1]  = drive_d;
    out_d[32:17] = cmd_d;
    out_d[33]    = steps_d != 9'd0;
    out_d[65:34] = cyc_d;
    out_d[66]    = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= '0;
      drive_q <= '0;
      hold_q  <= '0;
      steps_q <= '0;
      on_q    <= '0;
      off_q   <= '0;
      cyc_q   <= '0;
    end else if (retire) begin
      cmd_q   <= cmd_d;
      drive_q <= drive_d;
      hold_q  <= hold_d;
      steps_q <= steps_d;
      on_q    <= on_d;
      off_q   <= off_d;
      cyc_q   <= cyc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (retire) out_q <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  // cycle counter only ever steps by one
  a_cyc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cyc_q != $past(cyc_q) |-> cyc_q == $past(cyc_q) + 32'd1)
    else $error("relay cycle counter jumped");

  // channel state moves only when a beat retires
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !retire |=> $stable(cmd_q) && $stable(drive_q) && $stable(hold_q) &&
                $stable(steps_q) && $stable(cyc_q))
    else $error("channel state changed without a retiring beat");

  // a tick during a pending hold only counts the hold down
  a_hold_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire && c3_q.op == OP_TICK && hold_q != 16'd0 |=>
      hold_q == $past(hold_q) - 16'd1 && $stable(drive_q) && $stable(steps_q))
    else $error("tick during hold did more than count down");

endmodule
